/* rtl/core/scp_pkg.sv */
`timescale 1ns / 1ps
package scp_pkg;

  // default sizing
  localparam int DEF_MAX_CHANNELS      = 32;
  localparam int DEF_SLOTS_PER_CHANNEL = 16;
  localparam int DEF_MAX_DEGREE        = 8;
  localparam int DEF_FRAC_BITS         = 16;

  // table word address wide enough for 64 channels x 16 slots
  localparam int CMD_ADDR_W  = 10;
  localparam int QUEUE_DEPTH = 2;

  // fixed slot layout within a channel
  localparam int SLOT_CENTRE = 9;
  localparam int SLOT_RECIP  = 10;
  localparam int SLOT_MIN    = 11;
  localparam int SLOT_MAX    = 12;

  // input kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_CONVERT = 1'b1;

  // command ops carried through the queue
  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_REJECT  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ANGLE   = 2'd1;
  localparam logic [1:0] ST_CHANNEL = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [4:0]            channel;
    logic [CMD_ADDR_W-1:0] addr;   // word address (write) or channel base (convert)
    logic [31:0]           data;   // table word (write) or angle (convert)
  } cmd_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_0000_0000_7FFF_FFFF;
    lo = -66'sh0_0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

/* rtl/core/servo_polynomial_calibration_core.sv */
`timescale 1ns / 1ps
// Channel   | Handshake                 | Payload
// ----------+---------------------------+------------------------------------------
// input     | in_valid / in_stall       | kind, channel, slot, table_word, angle
// output    | out_valid / out_stall     | position, status, channel_echo
// config    | psel/penable/pwrite/pready| paddr, pwdata, prdata (channel_count @ 0)
//
// Writes retire at the queue head; a channel reject passes through S_OUT, an angle reject
// through S_MIN, S_MAX and S_OUT, and a convert through S_MIN to S_Z, one S_MUL/S_ADD pair
// per Horner step and S_OUT, paced by the single shared multiplier and the table's one read port.
// Reset (rst, synchronous) empties the queue and the output register and restores
// channel_count to 18; the calibration table is not cleared. A 2-entry queue between front
// and back keeps the input accepting while the back end works; in_stall rises only when full.
module servo_polynomial_calibration_core #(
  parameter int MAX_CHANNELS      = scp_pkg::DEF_MAX_CHANNELS,
  parameter int SLOTS_PER_CHANNEL = scp_pkg::DEF_SLOTS_PER_CHANNEL,
  parameter int MAX_DEGREE        = scp_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS         = scp_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  // config port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               kind,
  input  logic [4:0]         channel,
  input  logic [3:0]         slot,
  input  logic signed [31:0] table_word,
  input  logic signed [31:0] angle,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic [1:0]         status,
  output logic [4:0]         channel_echo
);
  import scp_pkg::*;

  // register index is the word address
  localparam logic REG_CHANNEL_COUNT = 1'b0;
  localparam logic [5:0] CHANNEL_COUNT_RESET = 6'd18;

  logic [5:0] channel_count;
  logic       cfg_write;
  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  cmd_t       push_cmd;
  cmd_t       q_head;

  // config register: to be written only while the core is idle; the block does not enforce this
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CHANNEL_COUNT) ? {26'd0, channel_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RESET;
    end else if (cfg_write && (paddr[2] == REG_CHANNEL_COUNT)) begin
      channel_count <= pwdata[5:0];
    end
  end

  // front: accept and classify
  scp_front #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL)
  ) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .channel       (channel),
    .slot          (slot),
    .table_word    (table_word),
    .angle         (angle),
    .channel_count (channel_count),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (push_cmd)
  );

  // command queue between the two halves
  scp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: table writes, range checks, Horner evaluation
  scp_back #(
    .MAX_CHANNELS      (MAX_CHANNELS),
    .SLOTS_PER_CHANNEL (SLOTS_PER_CHANNEL),
    .MAX_DEGREE        (MAX_DEGREE),
    .FRAC_BITS         (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_head       (q_head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position     (position),
    .status       (status),
    .channel_echo (channel_echo)
  );

endmodule

/* rtl/core/scp_ram.sv */
`timescale 1ns / 1ps
module scp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/scp_queue.sv */
`timescale 1ns / 1ps
module scp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  scp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output scp_pkg::cmd_t head,
  output logic          empty
);
  import scp_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/scp_front.sv */
`timescale 1ns / 1ps
module scp_front #(
  parameter int MAX_CHANNELS      = scp_pkg::DEF_MAX_CHANNELS,
  parameter int SLOTS_PER_CHANNEL = scp_pkg::DEF_SLOTS_PER_CHANNEL
) (
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                kind,
  input  logic [4:0]          channel,
  input  logic [3:0]          slot,
  input  logic signed [31:0]  table_word,
  input  logic signed [31:0]  angle,
  input  logic [5:0]          channel_count,
  input  logic                q_full,
  output logic                push,
  output scp_pkg::cmd_t       push_cmd
);
  import scp_pkg::*;

  logic ch_in_table;
  logic slot_in_table;
  logic ch_enabled;
  logic keep;

  assign ch_in_table   = int'(channel) < MAX_CHANNELS;
  assign slot_in_table = int'(slot) < SLOTS_PER_CHANNEL;
  assign ch_enabled    = ({1'b0, channel} < channel_count) && ch_in_table;

  // writes outside the table are accepted and dropped here
  assign keep     = (kind == KIND_CONVERT) || (ch_in_table && slot_in_table);
  assign in_stall = q_full;
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    push_cmd.channel = channel;
    if (kind == KIND_WRITE) begin
      push_cmd.op   = OP_WRITE;
      push_cmd.addr = CMD_ADDR_W'(int'(channel) * SLOTS_PER_CHANNEL + int'(slot));
      push_cmd.data = table_word;
    end else begin
      push_cmd.op   = ch_enabled ? OP_CONVERT : OP_REJECT;
      push_cmd.addr = CMD_ADDR_W'(int'(channel) * SLOTS_PER_CHANNEL);
      push_cmd.data = angle;
    end
  end

endmodule

/* rtl/core/scp_back.sv */
`timescale 1ns / 1ps
module scp_back #(
  parameter int MAX_CHANNELS      = scp_pkg::DEF_MAX_CHANNELS,
  parameter int SLOTS_PER_CHANNEL = scp_pkg::DEF_SLOTS_PER_CHANNEL,
  parameter int MAX_DEGREE        = scp_pkg::DEF_MAX_DEGREE,
  parameter int FRAC_BITS         = scp_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  scp_pkg::cmd_t      q_head,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic [1:0]         status,
  output logic [4:0]         channel_echo
);
  import scp_pkg::*;

  localparam int DEPTH = MAX_CHANNELS * SLOTS_PER_CHANNEL;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(MAX_DEGREE + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MIN  = 4'd1;
  localparam logic [3:0] S_MAX  = 4'd2;
  localparam logic [3:0] S_CEN  = 4'd3;
  localparam logic [3:0] S_RCP  = 4'd4;
  localparam logic [3:0] S_Z    = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_ADD  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [4:0]          cur_channel;
  logic [AW-1:0]       cur_base;
  logic signed [31:0]  cur_angle;
  logic                below_min;
  logic [KW-1:0]       k;
  logic signed [32:0]  diff;
  logic signed [64:0]  prod;
  logic signed [31:0]  z;
  logic signed [31:0]  acc;
  logic signed [31:0]  coef;
  logic signed [31:0]  res_pos;
  logic [1:0]          res_status;

  logic                ram_we;
  logic [AW-1:0]       ram_raddr;
  logic [AW-1:0]       rd_base;
  logic [31:0]         ram_rdata;
  logic signed [31:0]  rd_word;
  logic signed [32:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [64:0]  mul_p;
  logic signed [64:0]  prod_sh;
  logic signed [65:0]  horner_sum;
  logic signed [31:0]  horner_acc;
  logic                out_free;

  assign rd_word  = $signed(ram_rdata);
  assign q_pop    = (state == S_IDLE) && !q_empty;
  assign ram_we   = q_pop && (q_head.op == OP_WRITE);
  assign out_free = !out_valid || !out_stall;

  scp_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (q_head.addr[AW-1:0]),
    .wdata (q_head.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read address runs one state ahead of the state that uses the word
  assign rd_base = (state == S_IDLE) ? q_head.addr[AW-1:0] : cur_base;

  always_comb begin
    case (state)
      S_IDLE:  ram_raddr = rd_base + AW'(SLOT_MIN);
      S_MIN:   ram_raddr = rd_base + AW'(SLOT_MAX);
      S_MAX:   ram_raddr = rd_base + AW'(SLOT_CENTRE);
      S_CEN:   ram_raddr = rd_base + AW'(SLOT_RECIP);
      S_RCP:   ram_raddr = rd_base + AW'(MAX_DEGREE);
      S_Z:     ram_raddr = rd_base + AW'(MAX_DEGREE - 1);
      S_ADD:   ram_raddr = rd_base + AW'(k) - 1'b1;
      default: ram_raddr = rd_base;
    endcase
  end

  // one shared multiplier: diff*recip for z, then acc*z per Horner step
  assign mul_a = (state == S_RCP) ? diff : 33'(acc);
  assign mul_b = (state == S_RCP) ? rd_word : z;
  assign mul_p = mul_a * mul_b;

  assign prod_sh    = prod >>> FRAC_BITS;
  assign horner_sum = 66'(prod_sh) + 66'(coef);
  assign horner_acc = sat32(horner_sum);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          case (q_head.op)
            OP_CONVERT: state_next = S_MIN;
            OP_REJECT:  state_next = S_OUT;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_MIN:  state_next = S_MAX;
      S_MAX:  state_next = (below_min || (cur_angle > rd_word)) ? S_OUT : S_CEN;
      S_CEN:  state_next = S_RCP;
      S_RCP:  state_next = S_Z;
      S_Z:    state_next = S_MUL;
      S_MUL:  state_next = S_ADD;
      S_ADD:  state_next = (k == '0) ? S_OUT : S_MUL;
      S_OUT:  state_next = out_free ? S_IDLE : S_OUT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur_channel <= q_head.channel;
        cur_base    <= q_head.addr[AW-1:0];
        cur_angle   <= $signed(q_head.data);
        res_pos     <= '0;
        res_status  <= ST_CHANNEL;
      end
      S_MIN: begin
        below_min <= cur_angle < rd_word;
      end
      S_MAX: begin
        res_status <= ST_ANGLE;
      end
      S_CEN: begin
        diff <= 33'(cur_angle) - 33'(rd_word);
      end
      S_RCP: begin
        prod <= mul_p;
      end
      S_Z: begin
        z   <= sat32(66'(prod_sh));
        acc <= rd_word;
        k   <= KW'(MAX_DEGREE - 1);
      end
      S_MUL: begin
        prod <= mul_p;
        coef <= rd_word;
      end
      S_ADD: begin
        acc <= horner_acc;
        k   <= k - 1'b1;
        if (k == '0) begin
          res_pos    <= horner_acc;
          res_status <= ST_OK;
        end
      end
      S_OUT: begin
        if (out_free) begin
          position     <= res_pos;
          status       <= res_status;
          channel_echo <= cur_channel;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import scp_pkg::*;

  // Block sizing as instantiated (package defaults).
  localparam int NUM_CH      = DEF_MAX_CHANNELS;
  localparam int NUM_SLOTS   = DEF_SLOTS_PER_CHANNEL;
  localparam int DEGREE      = DEF_MAX_DEGREE;
  localparam int FRAC        = DEF_FRAC_BITS;
  localparam int USED_SLOTS  = SLOT_MAX + 1;          // slots 13..15 are never read
  localparam int TABLE_WORDS = NUM_CH * NUM_SLOTS;

  localparam logic [2:0] ADDR_CHANNEL_COUNT = 3'd0;
  localparam int RESET_CHANNEL_COUNT = 18;

  // Idle-gap bound per item, long receiver hold, quiet window after each
  // drain, and the no-progress watchdog.
  localparam int MAX_GAP     = 4;
  localparam int LONG_HOLD   = 400;
  localparam int SETTLE_CYC  = 100;
  localparam int QUIET_LIMIT = 5000;

  typedef struct {
    logic               kind;
    logic [4:0]         channel;
    logic [3:0]         slot;
    logic signed [31:0] table_word;
    logic signed [31:0] angle;
    bit                 drain_first;   // sender waits for all results before this item
  } servo_cmd_t;

  typedef struct {
    logic signed [31:0] position;
    logic [1:0]         status;
    logic [4:0]         channel_echo;
  } servo_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               psel       = 1'b0;
  logic               penable    = 1'b0;
  logic               pwrite     = 1'b0;
  logic [2:0]         paddr      = '0;
  logic [31:0]        pwdata     = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               kind       = 1'b0;
  logic [4:0]         channel    = '0;
  logic [3:0]         slot       = '0;
  logic signed [31:0] table_word = '0;
  logic signed [31:0] angle      = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic signed [31:0] position;
  logic [1:0]         status;
  logic [4:0]         channel_echo;

  servo_polynomial_calibration_core dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .channel      (channel),
    .slot         (slot),
    .table_word   (table_word),
    .angle        (angle),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .position     (position),
    .status       (status),
    .channel_echo (channel_echo)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  servo_cmd_t    pending_items[$];        // filled by the sequence, drained by the driver
  servo_result_t expected_positions[$];   // oldest first
  int            mismatches = 0;

  // Predictor's own copy of the calibration table and channel_count.
  logic signed [31:0] cal_words [0:TABLE_WORDS-1];
  int                 pred_count = RESET_CHANNEL_COUNT;

  // Generator shadow: what has been loaded per channel, so converts only ever
  // touch fully written tables and angles can be aimed at the window edges.
  longint g_word [0:NUM_CH-1][0:USED_SLOTS-1];
  bit     g_set  [0:NUM_CH-1][0:USED_SLOTS-1];
  int     gen_count    = RESET_CHANNEL_COUNT;
  int     items_queued = 0;
  bit     drain_next   = 1'b0;

  // Driver / receiver bookkeeping
  servo_cmd_t cur_item;
  bit         drv_busy   = 1'b0;
  int         gap_left   = 0;
  bit         tx_calm    = 1'b0;   // stretch without sender gaps
  int         stall_left = 0;
  int         hold_left  = 0;
  int         hold_req   = 0;
  int         hold_done  = 0;
  bit         rx_calm    = 1'b0;   // stretch without receiver stalls
  int         quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint cal_word(input int ch, input int s);
    return longint'(cal_words[ch * NUM_SLOTS + s]);
  endfunction

  // Applies one item to the predictor state; a convert yields one result.
  function automatic void predict_position(input servo_cmd_t it, output bit produced,
                                           output servo_result_t res);
    longint a, diff, z, acc;
    int ch;
    ch = int'(it.channel);
    produced = 1'b0;
    res.position = '0;
    res.status = ST_OK;
    res.channel_echo = it.channel;
    if (it.kind == KIND_WRITE) begin
      // 5-bit channel / 4-bit slot always land inside the table at default sizing
      cal_words[ch * NUM_SLOTS + int'(it.slot)] = it.table_word;
      return;
    end
    produced = 1'b1;
    a = longint'(it.angle);
    if (ch >= pred_count || ch >= NUM_CH) begin
      res.status = ST_CHANNEL;
    end else if (a < cal_word(ch, SLOT_MIN) || a > cal_word(ch, SLOT_MAX)) begin
      res.status = ST_ANGLE;
    end else begin
      diff = a - cal_word(ch, SLOT_CENTRE);                       // exact, 33 bits
      z = clamp32((diff * cal_word(ch, SLOT_RECIP)) >>> FRAC);    // floor shift
      acc = cal_word(ch, DEGREE);
      for (int k = DEGREE - 1; k >= 0; k--) begin
        acc = clamp32(((acc * z) >>> FRAC) + cal_word(ch, k));
      end
      res.position = acc[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------
  function automatic void queue_item(input logic k, input int ch, input int sl,
                                     input logic [31:0] w, input logic [31:0] a);
    servo_cmd_t it;
    it.kind        = k;
    it.channel     = ch[4:0];
    it.slot        = sl[3:0];
    it.table_word  = w;
    it.angle       = a;
    it.drain_first = drain_next;
    drain_next     = 1'b0;
    pending_items.push_back(it);
    items_queued++;
    if (k == KIND_WRITE && sl < USED_SLOTS) begin
      g_word[ch][sl] = longint'($signed(w));
      g_set[ch][sl]  = 1'b1;
    end
  endfunction

  // Full table load. style 1 = random words with a full angle window (deep
  // saturation), 2 = fully random (min > max half the time), else a gentle curve.
  function automatic void load_channel(input int ch, input int style);
    longint w [0:USED_SLOTS-1];
    longint c, h, t;
    int d, off, s;
    if (style == 1 || style == 2) begin
      for (int k = 0; k < USED_SLOTS; k++) w[k] = longint'($signed($urandom));
      if (style == 1) begin
        w[SLOT_MIN] = -64'sd2147483648;
        w[SLOT_MAX] = 64'sd2147483647;
      end
    end else begin
      c = longint'($urandom_range(0, 180 * 65536)) - 90 * 65536;
      h = longint'($urandom_range(65536, 90 * 65536));
      w[SLOT_CENTRE] = c;
      w[SLOT_RECIP]  = 64'h1_0000_0000 / h;   // 1/h in Q16.16, keeps |z| <= 1.0
      w[SLOT_MIN]    = c - h;
      w[SLOT_MAX]    = c + h;
      if ($urandom_range(0, 9) == 0) begin     // inverted window rejects all angles
        t = w[SLOT_MIN];
        w[SLOT_MIN] = w[SLOT_MAX];
        w[SLOT_MAX] = t;
      end
      d = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 8;
      for (int k = 0; k <= 8; k++) begin
        w[k] = (k <= d) ? longint'($urandom_range(0, 1 << 18)) - (1 << 17) : 0;
      end
    end
    off = $urandom_range(0, USED_SLOTS - 1);
    for (int i = 0; i < USED_SLOTS; i++) begin
      s = (i + off) % USED_SLOTS;
      queue_item(KIND_WRITE, ch, s, w[s][31:0], $urandom);
    end
  endfunction

  function automatic void ensure_loaded(input int ch);
    for (int s = 0; s < USED_SLOTS; s++) begin
      if (!g_set[ch][s]) begin
        load_channel(ch, $urandom_range(0, 3));
        return;
      end
    end
  endfunction

  // Mostly inside the window, with the edges and just-outside values favored.
  function automatic logic [31:0] pick_angle(input int ch);
    longint mn, mx, span, a;
    int r;
    mn = g_word[ch][SLOT_MIN];
    mx = g_word[ch][SLOT_MAX];
    r = $urandom_range(0, 99);
    if (r < 60 && mn <= mx) begin
      span = mx - mn + 1;
      a = mn + longint'({$urandom, $urandom} % span);
    end else if (r < 67) begin
      a = mn;
    end else if (r < 74) begin
      a = mx;
    end else if (r < 80) begin
      a = mn - 1 - $urandom_range(0, 255);
    end else if (r < 86) begin
      a = mx + 1 + $urandom_range(0, 255);
    end else if (r < 92) begin
      a = g_word[ch][SLOT_CENTRE];
    end else begin
      a = longint'($signed($urandom));
    end
    if (a > 64'sd2147483647 || a < -64'sd2147483648) a = longint'($signed($urandom));
    return a[31:0];
  endfunction

  function automatic void gen_random_items(input int n);
    int stop_at, r, ch;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) == 0) drain_next = 1'b1;
      if (r < 50 && gen_count > 0) begin
        // well-formed convert on a live channel
        ch = $urandom_range(0, gen_count - 1);
        ensure_loaded(ch);
        queue_item(KIND_CONVERT, ch, $urandom_range(0, 15), $urandom, pick_angle(ch));
      end else if (r < 60) begin
        load_channel($urandom_range(0, NUM_CH - 1), $urandom_range(0, 3));
      end else if (r < 72) begin
        // lone write, any slot including the unused ones
        queue_item(KIND_WRITE, $urandom_range(0, NUM_CH - 1), $urandom_range(0, 15),
                   $urandom, $urandom);
      end else if (r < 86) begin
        ch = $urandom_range(0, NUM_CH - 1);
        if (ch < gen_count) ensure_loaded(ch);
        queue_item(KIND_CONVERT, ch, $urandom_range(0, 15), $urandom, $urandom);
      end else begin
        // aimed at the channel reject
        ch = (gen_count < NUM_CH) ? $urandom_range(gen_count, NUM_CH - 1)
                                  : $urandom_range(0, NUM_CH - 1);
        if (ch < gen_count) ensure_loaded(ch);
        queue_item(KIND_CONVERT, ch, $urandom_range(0, 15), $urandom, $urandom);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: payload changes on the falling edge, acceptance seen on the
  // rising edge. A stalled item is held unchanged.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && !drv_busy) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].drain_first && expected_positions.size() != 0)) begin
        cur_item = pending_items.pop_front();
        kind       <= cur_item.kind;
        channel    <= cur_item.channel;
        slot       <= cur_item.slot;
        table_word <= cur_item.table_word;
        angle      <= cur_item.angle;
        in_valid   <= 1'b1;
        drv_busy   = 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : tx_accept
    servo_result_t res;
    bit produced;
    if (!rst && in_valid && !in_stall) begin
      predict_position(cur_item, produced, res);
      if (produced) expected_positions.push_back(res);
      drv_busy = 1'b0;
      gap_left = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per item, plus one long hold on request so
  // the internal queue fills and the block pushes back on its input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : rx_check
    servo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_positions.size() == 0) begin
        $error("result with nothing pending: position %0d status %0d channel %0d",
               position, status, channel_echo);
        mismatches++;
      end else begin
        want = expected_positions.pop_front();
        if (position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, position);
          mismatches++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          mismatches++;
        end
        if (channel_echo !== want.channel_echo) begin
          $error("channel_echo: expected %0d, got %0d", want.channel_echo, channel_echo);
          mismatches++;
        end
      end
      stall_left = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
    end
  end

  // No-progress watchdog: any handshake or config access resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config port access (setup + access phase)
  // ---------------------------------------------------------------------------
  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_channel_count();
    logic [31:0] rd;
    apb_access(1'b0, ADDR_CHANNEL_COUNT, '0, rd);
    if (rd[5:0] !== pred_count[5:0]) begin
      $error("channel_count readback: expected %0d, got %0d", pred_count, rd[5:0]);
      mismatches++;
    end
  endtask

  task automatic set_channel_count(input int cnt);
    logic [31:0] rd;
    apb_access(1'b1, ADDR_CHANNEL_COUNT, {26'd0, cnt[5:0]}, rd);
    pred_count = cnt;
    gen_count  = cnt;
    check_channel_count();
  endtask

  // Block is idle once the driver is empty and every result is back; writes
  // leave no result, so give the back end its convert latency on top.
  task automatic settle();
    while (pending_items.size() != 0 || drv_busy || expected_positions.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    longint c0, h0;
    logic [31:0] ch0_words [0:USED_SLOTS-1];
    int plan [0:7];
    int cnt;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    check_channel_count();   // reset value

    // Directed: channel 0 gets a known curve, 10 deg centre, +/-45 deg window.
    c0 = 10 * 65536;
    h0 = 45 * 65536;
    ch0_words = '{25841, -5138, 43, 27565, 197, 0, -3, 0, -65536,
                  c0[31:0], 32'(64'h1_0000_0000 / h0), 32'(c0 - h0), 32'(c0 + h0)};
    for (int s = 0; s < USED_SLOTS; s++) begin
      queue_item(KIND_WRITE, 0, s, ch0_words[s], $urandom);
    end
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0 - h0));        // at min
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0 + h0));        // at max
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0 - h0 - 1));    // just below min
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0 + h0 + 1));    // just above max
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0));             // z = 0 -> coefficient 0
    queue_item(KIND_CONVERT, 0, 15, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    queue_item(KIND_CONVERT, RESET_CHANNEL_COUNT, 0, 0, 32'(c0));   // first rejected ch
    queue_item(KIND_CONVERT, NUM_CH - 1, 0, 0, 32'h8000_0000);
    queue_item(KIND_WRITE, NUM_CH - 1, 15, 32'h8000_0000, 0);       // stored, never read
    queue_item(KIND_WRITE, 0, USED_SLOTS, 32'h7FFF_FFFF, 0);        // unused slot
    queue_item(KIND_CONVERT, 0, 0, 0, 32'(c0 + 1));

    // Channel-count plan: extremes, the reject-all setting, and random ones.
    plan = '{NUM_CH, 1, 0, $urandom_range(2, NUM_CH - 1), NUM_CH,
             $urandom_range(2, NUM_CH - 1), $urandom_range(2, NUM_CH - 1), NUM_CH};
    for (int p = 0; p < 8; p++) begin
      settle();
      set_channel_count(plan[p]);
      if (p == 4) hold_req++;          // long receiver hold while the sender keeps going
      if (p == 5) drain_next = 1'b1;   // sender waits for a full drain
      cnt = (plan[p] == 0) ? 40 : 270;
      gen_random_items(cnt);
    end
    settle();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
